@@ hw/rtl/three_level_priority_queue_core_defines.svh @@
// Assertion macros shared by the queue checker.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define TLPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define TLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tlpq_pkg.sv @@
// Package: word types, codes and defaults of the three-level priority queue.
`timescale 1ns / 1ps
package tlpq_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_ACCEL = 2'd2;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_NORM = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  level;
    logic [31:0] payload;
  } in_word_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Level three stands for high.
  function automatic logic [1:0] sat_level(input logic [1:0] l);
    return (l > LVL_HIGH) ? LVL_HIGH : l;
  endfunction

endpackage

@@ hw/rtl/tlpq_if.sv @@
// Interface: valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps
interface tlpq_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/three_level_priority_queue_core.sv @@
// Top level: three FIFO levels over one linked-list store with a free list.
//
//   channel | dir | word                              | accepted when
//   --------+-----+-----------------------------------+----------------------
//   req     | in  | opcode, level, payload            | req.valid & req.ready
//   rsp     | out | data_out, status                  | rsp.valid & rsp.ready
//
// Each item passes two states: accept issues the read of the link memory
// (and data memory), the commit state that follows uses the read data and commits.
// Because the link memory read is registered, a new item waits until the last has committed.
// Reset (synchronous) empties all levels; no clearing pass is run:
// links past the fill mark read as the initial free chain.
// A result waits in the output register; while it is not taken the commit
// cycle holds, and req.ready stays low.
`timescale 1ns / 1ps
module three_level_priority_queue_core #(
  parameter int CAPACITY   = tlpq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = tlpq_pkg::DATA_WIDTH_DEF
) (
  input logic  clk,
  input logic  rst,
  tlpq_if.sink   req,
  tlpq_if.source rsp
);
  import tlpq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NLVL = 3;

  // Step an entry index, wrapping at the store size.
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == AW'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  // Storage: payloads and links, each with a registered read.
  logic [DATA_WIDTH-1:0] entry_data [CAPACITY];
  logic [AW-1:0]         entry_next [CAPACITY];
  logic [DATA_WIDTH-1:0] data_rdata;
  logic [AW-1:0]         next_rdata;

  // Queue bookkeeping.
  logic [AW-1:0] level_head [NLVL];
  logic [AW-1:0] level_tail [NLVL];
  logic [CW-1:0] level_count [NLVL];
  logic [AW-1:0] free_head;
  logic [CW-1:0] free_count;
  logic [CW-1:0] fill_mark;  // entries below have had their link written

  logic [AW-1:0] level_head_next [NLVL];
  logic [AW-1:0] level_tail_next [NLVL];
  logic [CW-1:0] level_count_next [NLVL];
  logic [AW-1:0] free_head_next;
  logic [CW-1:0] free_count_next;
  logic [CW-1:0] fill_mark_next;

  state_t state, state_next;
  logic [1:0]    op_q;
  logic [1:0]    lvl_q;
  logic [AW-1:0] rd_idx_q;

  logic      out_valid;
  out_word_t out_word;
  out_word_t result;

  // Control decode.
  logic          accept;
  logic          advance;
  logic [1:0]    cur_op;
  logic [1:0]    cur_lvl;
  logic [1:0]    get_lvl;
  logic          any_queued;
  logic [1:0]    pick;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] link_next;
  logic [63:0]   pay_wide;
  logic [63:0]   rd_wide;

  // Memory write ports.
  logic                  data_we;
  logic [AW-1:0]         data_waddr;
  logic [DATA_WIDTH-1:0] data_wdata;
  logic                  next_we;
  logic [AW-1:0]         next_waddr;
  logic [AW-1:0]         next_wdata;

  assign req.ready = (state == S_IDLE) && !rst;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  assign accept  = req.valid && req.ready;
  assign advance = (state == S_EXEC) && (!out_valid || rsp.ready);

  // Highest nonempty level for get.
  always_comb begin
    any_queued = 1'b1;
    if (level_count[LVL_HIGH] != '0) begin
      get_lvl = LVL_HIGH;
    end else if (level_count[LVL_NORM] != '0) begin
      get_lvl = LVL_NORM;
    end else begin
      get_lvl = LVL_LOW;
      any_queued = (level_count[LVL_LOW] != '0);
    end
  end

  assign cur_op  = (state == S_IDLE) ? req.data.opcode : op_q;
  assign cur_lvl = (state == S_IDLE) ? sat_level(req.data.level) : lvl_q;
  assign pick    = (cur_op == OP_GET) ? get_lvl : cur_lvl;
  assign rd_addr = (cur_op == OP_GET) ? level_head[pick] : free_head;

  // Links never written read as the reset chain i -> i+1, wrapping at the store size.
  assign link_next = (CW'(rd_idx_q) >= fill_mark) ? wrap_inc(rd_idx_q) : next_rdata;

  assign pay_wide = 64'(req.data.payload);
  assign rd_wide  = 64'(data_rdata);

  // Next state, bookkeeping and memory writes.
  always_comb begin
    state_next       = state;
    level_head_next  = level_head;
    level_tail_next  = level_tail;
    level_count_next = level_count;
    free_head_next   = free_head;
    free_count_next  = free_count;
    fill_mark_next   = fill_mark;
    result           = '{data_out: '0, status: ST_DONE};
    data_we          = 1'b0;
    data_waddr       = free_head;
    data_wdata       = pay_wide[DATA_WIDTH-1:0];
    next_we          = 1'b0;
    next_waddr       = free_head;
    next_wdata       = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
          // Put: store payload and hook the new entry behind the tail now.
          if (cur_op == OP_PUT && free_count != '0) begin
            data_we = 1'b1;
            if (level_count[pick] != '0) begin
              next_we    = 1'b1;
              next_waddr = level_tail[pick];
              next_wdata = free_head;
            end
          end
        end
      end
      S_EXEC: begin
        if (advance) begin
          state_next = S_IDLE;
          case (op_q)
            OP_PUT: begin
              if (free_count == '0) begin
                result.status = ST_FULL;
              end else begin
                next_we    = 1'b1;
                next_waddr = free_head;
                next_wdata = '0;
                free_head_next  = link_next;
                free_count_next = free_count - 1'b1;
                if (CW'(free_head) >= fill_mark) begin
                  fill_mark_next = fill_mark + 1'b1;
                end
                if (level_count[pick] == '0) begin
                  level_head_next[pick] = free_head;
                end
                level_tail_next[pick]  = free_head;
                level_count_next[pick] = level_count[pick] + 1'b1;
              end
            end
            OP_GET: begin
              if (!any_queued) begin
                result.status = ST_EMPTY;
              end else begin
                result.data_out = rd_wide[31:0];
                next_we    = 1'b1;
                next_waddr = level_head[pick];
                next_wdata = free_head;
                level_head_next[pick]  = link_next;
                level_count_next[pick] = level_count[pick] - 1'b1;
                free_head_next  = level_head[pick];
                free_count_next = free_count + 1'b1;
              end
            end
            OP_ACCEL: begin
              if (level_count[LVL_LOW] != '0) begin
                if (level_count[LVL_HIGH] == '0) begin
                  level_head_next[LVL_HIGH] = level_head[LVL_LOW];
                end else begin
                  next_we    = 1'b1;
                  next_waddr = level_tail[LVL_HIGH];
                  next_wdata = level_head[LVL_LOW];
                end
                level_tail_next[LVL_HIGH]  = level_tail[LVL_LOW];
                level_count_next[LVL_HIGH] = level_count[LVL_HIGH] + level_count[LVL_LOW];
                level_count_next[LVL_LOW]  = '0;
                level_head_next[LVL_LOW]   = '0;
                level_tail_next[LVL_LOW]   = '0;
              end
            end
            default: begin
              // Unused opcode: report done, touch nothing.
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NLVL; i++) begin
        level_head[i]  <= '0;
        level_tail[i]  <= '0;
        level_count[i] <= '0;
      end
      free_head  <= '0;
      free_count <= CW'(CAPACITY);
      fill_mark  <= '0;
    end else begin
      level_head  <= level_head_next;
      level_tail  <= level_tail_next;
      level_count <= level_count_next;
      free_head   <= free_head_next;
      free_count  <= free_count_next;
      fill_mark   <= fill_mark_next;
    end
  end

  // Latch the item's decode for the commit cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= cur_op;
      lvl_q    <= cur_lvl;
      rd_idx_q <= rd_addr;
    end
  end

  // Payload memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (data_we) begin
      entry_data[data_waddr] <= data_wdata;
    end
    if (accept) begin
      data_rdata <= entry_data[rd_addr];
    end
  end

  // Link memory: one write, one registered read; hold read data through stalls.
  always_ff @(posedge clk) begin
    if (next_we) begin
      entry_next[next_waddr] <= next_wdata;
    end
    if (accept) begin
      next_rdata <= entry_next[rd_addr];
    end
  end

  // Output register: load on commit, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

endmodule

@@ hw/rtl/tlpq_check.sv @@
// Checker: port-level assertions on the queue core, bound to the top level.
`timescale 1ns / 1ps
`include "three_level_priority_queue_core_defines.svh"
module tlpq_check (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input tlpq_pkg::out_word_t rsp_data
);
  import tlpq_pkg::*;

  // An accepted word keeps the core busy for its commit cycle.
  `TLPQ_ASSERT_NEXT(a_no_back_to_back, req_valid && req_ready, !req_ready, "accept right after accept")

  // Only a successful get carries data.
  `TLPQ_ASSERT_NOW(a_zero_on_fail, rsp_valid && rsp_data.status != ST_DONE, rsp_data.data_out == '0, "data on failed item")

  `TLPQ_ASSERT_NOW(a_status_code, rsp_valid, rsp_data.status == ST_DONE || rsp_data.status == ST_EMPTY || rsp_data.status == ST_FULL, "bad status code")

  `TLPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind three_level_priority_queue_core tlpq_check u_tlpq_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
